FILE: rtl/rpdf_pkg.sv
// rpdf_pkg: shared types, codes and constants of the read pair duplicate filter.
// No dependencies.
package rpdf_pkg;

  localparam int unsigned SetCapacity = 65536;
  localparam int unsigned SlotWidth   = $clog2(SetCapacity);
  localparam int unsigned CountWidth  = SlotWidth + 1;

  localparam logic [1:0] CfgSkipRead1 = 2'd0;
  localparam logic [1:0] CfgKeyLenRead1 = 2'd1;
  localparam logic [1:0] CfgSkipRead2 = 2'd2;
  localparam logic [1:0] CfgKeyLenRead2 = 2'd3;

  localparam logic [2:0] VerdictUnique    = 3'd0;
  localparam logic [2:0] VerdictDuplicate = 3'd1;
  localparam logic [2:0] VerdictShort     = 3'd2;
  localparam logic [2:0] VerdictBadBase   = 3'd3;
  localparam logic [2:0] VerdictFull      = 3'd4;

  localparam logic [63:0] HashMult = 64'h9E37_79B9_7F4A_7C15;

  typedef struct packed {
    logic [7:0] base;
    logic       base_present;
    logic       second_read;
    logic       end_of_read;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [63:0] pair_key;
    logic [31:0] unique_count;
    logic [31:0] duplicate_count;
    logic [31:0] discard_count;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_item;     // absorb the input transaction
    logic clear_start;   // reset clear pointer
    logic clear_step;    // write one invalid entry
    logic hash_start;    // load key into hash pipeline
    logic hash_step;     // advance hash pipeline
    logic probe_read;    // issue read at probe slot
    logic probe_eval;    // evaluate read data
    logic probe_next;    // move to next slot
    logic finish;        // emit result
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_done;
    logic verdict_now;   // read-2 close: verdict needed
    logic needs_probe;   // verdict goes to the set
    logic hash_done;
    logic probe_hit;     // evaluation finished (free slot, match or full)
    logic out_busy;      // output register still full
  } dp_status_t;

  function automatic logic [2:0] base_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      8'h43, 8'h63: r = 3'd0;
      8'h41, 8'h61: r = 3'd1;
      8'h54, 8'h74: r = 3'd2;
      8'h47, 8'h67: r = 3'd3;
      default:      r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

FILE: rtl/rpdf_ram.sv
// rpdf_ram: generic single-port RAM with registered read.
// No dependencies.
module rpdf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/rpdf_ctrl.sv
// rpdf_ctrl: sequencer of the duplicate filter (clear sweep, hash, probe).
// Depends on rpdf_pkg.
module rpdf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpdf_pkg::dp_status_t sts,
  output rpdf_pkg::dp_cmd_t    cmd
);
  import rpdf_pkg::*;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_IDLE  = 7'b0000100,
    S_HASH  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_EVAL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE) || sts.out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_INIT: begin
        cmd.clear_start = 1'b1;
        state_next = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.take_item = 1'b1;
          if (sts.verdict_now) begin
            if (sts.needs_probe) begin
              cmd.hash_start = 1'b1;
              state_next = S_HASH;
            end else begin
              cmd.finish = 1'b1;
            end
          end
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) state_next = S_READ;
      end
      S_READ: begin
        cmd.probe_read = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.probe_eval = 1'b1;
        if (sts.probe_hit) begin
          state_next = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item |-> state == S_IDLE && !sts.out_busy)
    else $error("item taken while busy");
  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.probe_eval |-> $past(cmd.probe_read))
    else $error("evaluation without read");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.out_busy)
    else $error("result overwrites pending output");
`endif
endmodule

FILE: rtl/rpdf_datapath.sv
// rpdf_datapath: key assembly, hashing, open-addressed set and counters.
// Depends on rpdf_pkg and rpdf_ram.
module rpdf_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  rpdf_pkg::in_item_t   item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  rpdf_pkg::dp_cmd_t    cmd,
  output rpdf_pkg::dp_status_t sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rpdf_pkg::out_item_t  out_item
);
  import rpdf_pkg::*;

  logic [7:0]  skip_read1, skip_read2;
  logic [5:0]  key_length_read1, key_length_read2;
  logic [8:0]  base_position;
  logic [63:0] key_accumulator;
  logic        bad_base_seen, read1_too_short;
  logic [CountWidth-1:0] stored_keys;
  logic [31:0] unique_total, duplicate_total, discard_total;

  logic [8:0]  skip, stop;
  logic [2:0]  code;
  logic        short_read;
  logic        in_window;
  logic [8:0]  pos_next;
  logic [63:0] key_next;
  logic        bad_next;

  // Clear sweep
  logic [SlotWidth-1:0] clear_ptr;
  logic                 valid_we;

  // Hash: 4 stages of 16x64 partial products, then fold.
  logic [63:0] hkey, hacc;
  logic [1:0]  hstep;
  logic        hfold;
  logic [63:0] hprod;
  logic [SlotWidth-1:0] slot;

  // Probe bookkeeping: slots evaluated so far for the current key
  logic [SlotWidth-1:0] probe_count;
  logic                 key_match, probe_last;

  logic        ram_we;
  logic [SlotWidth-1:0] ram_addr;
  logic [64:0] ram_wdata, ram_rdata;
  logic [2:0]  verdict_reg;

  assign skip = {1'b0, item.second_read ? skip_read2 : skip_read1};
  assign stop = skip + {3'b0, item.second_read ? key_length_read2 : key_length_read1};
  assign code = base_code(item.base);

  // Values after the current transaction; the closing base counts too.
  assign in_window  = item.base_present && base_position >= skip && base_position < stop;
  assign key_next   = (in_window && !code[2]) ? {key_accumulator[61:0], code[1:0]}
                                              : key_accumulator;
  assign bad_next   = bad_base_seen || (in_window && code[2]);
  assign pos_next   = (item.base_present && base_position != 9'd511)
                      ? base_position + 9'd1 : base_position;
  assign short_read = pos_next < stop;

  assign key_match  = ram_rdata[64] && ram_rdata[63:0] == hkey;
  assign probe_last = (probe_count == SlotWidth'(SetCapacity - 1));

  assign sts.verdict_now = item.end_of_read && item.second_read;
  assign sts.needs_probe = !(read1_too_short || short_read) && !bad_next;
  assign sts.clear_done  = (clear_ptr == SlotWidth'(SetCapacity - 1));
  assign sts.hash_done   = hfold;
  assign sts.out_busy    = out_valid && out_stall;
  // Stop on a free slot, a match, or once every slot has been looked at.
  assign sts.probe_hit   = !ram_rdata[64] || key_match || probe_last;

  assign hprod = hkey * {48'b0, HashMult[hstep*16 +: 16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_read1 <= 8'd5; skip_read2 <= 8'd5;
      key_length_read1 <= 6'd16; key_length_read2 <= 6'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgSkipRead1:   skip_read1 <= cfg_data;
        CfgKeyLenRead1: key_length_read1 <= cfg_data[5:0];
        CfgSkipRead2:   skip_read2 <= cfg_data;
        CfgKeyLenRead2: key_length_read2 <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Read assembly
  always_ff @(posedge clk) begin
    if (rst) begin
      base_position <= '0; key_accumulator <= '0;
      bad_base_seen <= 1'b0; read1_too_short <= 1'b0;
    end else if (cmd.take_item) begin
      if (item.end_of_read) begin
        base_position <= '0;
        if (!item.second_read) begin
          key_accumulator <= key_next;
          bad_base_seen <= bad_next;
          if (short_read) read1_too_short <= 1'b1;
        end else begin
          key_accumulator <= '0;
          bad_base_seen <= 1'b0;
          read1_too_short <= 1'b0;
        end
      end else begin
        base_position <= pos_next;
        key_accumulator <= key_next;
        bad_base_seen <= bad_next;
      end
    end
  end

  // Hash pipeline and probe slot
  always_ff @(posedge clk) begin
    if (cmd.hash_start) begin
      hkey <= key_next; hacc <= '0; hstep <= '0; hfold <= 1'b0;
    end else if (cmd.hash_step && !hfold) begin
      hacc <= hacc + (hprod << (hstep * 16));
      hstep <= hstep + 2'd1;
      if (hstep == 2'd3) hfold <= 1'b1;
    end
    if (cmd.hash_step && hfold) slot <= SlotWidth'(hacc ^ (hacc >> 29));
    else if (cmd.probe_next) slot <= slot + SlotWidth'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_start) probe_count <= '0;
    else if (cmd.probe_next) probe_count <= probe_count + SlotWidth'(1);
  end

  // Clear sweep writes the valid flag low in every entry.
  always_ff @(posedge clk) begin
    if (cmd.clear_start) clear_ptr <= '0;
    else if (cmd.clear_step && !sts.clear_done) clear_ptr <= clear_ptr + SlotWidth'(1);
  end
  assign valid_we = cmd.clear_step || cmd.clear_start;

  logic store_new, full_new;
  assign full_new  = !ram_rdata[64] && stored_keys >= CountWidth'(SetCapacity);
  assign store_new = cmd.probe_eval && !ram_rdata[64] && !full_new;

  assign ram_we    = valid_we || store_new;
  assign ram_addr  = valid_we ? (cmd.clear_start ? '0 : clear_ptr) : slot;
  assign ram_wdata = valid_we ? 65'b0 : {1'b1, hkey};

  rpdf_ram #(.Width(65), .Depth(SetCapacity)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.probe_eval && sts.probe_hit) begin
      verdict_reg <= key_match ? VerdictDuplicate
                   : (ram_rdata[64] ? VerdictFull
                   : (full_new ? VerdictFull : VerdictUnique));
    end
  end

  // Counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_keys <= '0; unique_total <= '0; duplicate_total <= '0;
      discard_total <= '0; out_valid <= 1'b0;
    end else begin
      if (store_new) stored_keys <= stored_keys + CountWidth'(1);
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (cmd.take_item) begin
          out_item.verdict  <= (read1_too_short || short_read) ? VerdictShort
                                                              : VerdictBadBase;
          out_item.pair_key <= '0;
          out_item.discard_count <= sat_inc(discard_total);
          discard_total <= sat_inc(discard_total);
          out_item.unique_count <= unique_total;
          out_item.duplicate_count <= duplicate_total;
        end else begin
          out_item.verdict <= verdict_reg;
          out_item.pair_key <= hkey;
          out_item.discard_count <= discard_total;
          out_item.unique_count <= (verdict_reg == VerdictUnique)
                                   ? sat_inc(unique_total) : unique_total;
          out_item.duplicate_count <= (verdict_reg == VerdictDuplicate)
                                      ? sat_inc(duplicate_total) : duplicate_total;
          if (verdict_reg == VerdictUnique) unique_total <= sat_inc(unique_total);
          if (verdict_reg == VerdictDuplicate)
            duplicate_total <= sat_inc(duplicate_total);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_keys <= CountWidth'(SetCapacity))
    else $error("stored key count beyond capacity");
  a_store_grows: assert property (@(posedge clk) disable iff (rst)
    store_new |=> stored_keys == $past(stored_keys) + CountWidth'(1))
    else $error("store did not count");
  a_discard_key_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.verdict == VerdictShort || out_item.verdict == VerdictBadBase)
    |-> out_item.pair_key == '0)
    else $error("discarded pair carries a key");
`endif
endmodule

FILE: rtl/read_pair_duplicate_filter_unit.sv
// Read pair duplicate filter: one base per transaction in, one verdict per pair out.
// After reset the key set is swept clear (one start step plus one write per entry),
// during which no input transaction is accepted (configuration writes still land).
// Bases are taken back to back unless the block is busy or a result is held. A read-2
// closing transaction that goes to the set holds the input while the key is hashed
// (four 16x64 partial-product steps plus a fold), each probed slot of the single-port
// key store is read and then evaluated, and the result is loaded. A discarded pair's
// verdict is loaded on the accepting edge itself. A result held by out_stall stops input.
// Depends on rpdf_pkg, rpdf_ctrl, rpdf_datapath, rpdf_ram.
module read_pair_duplicate_filter_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpdf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rpdf_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import rpdf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Controller: clear sweep, per-item acceptance, hash and probe sequencing.
  rpdf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  // Datapath: key window, set memory, counters and output register.
  rpdf_datapath u_dp (
    .clk(clk), .rst(rst), .item(in_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .sts(sts), .out_valid(out_valid),
    .out_stall(out_stall), .out_item(out_item)
  );
endmodule

FILE: test/tb_top.sv
// Testbench for read_pair_duplicate_filter_unit: streams paired reads, predicts each pair verdict,
// key and running counts, and checks every result transaction in order.
// Depends on rpdf_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  import rpdf_pkg::*;

  // Verdict predictor plus the queue of verdicts still owed by the block.
  class verdict_board;
    logic [7:0]  skip1, skip2;
    logic [5:0]  klen1, klen2;
    int unsigned position;
    logic [63:0] key_acc;
    bit          bad_seen, r1_short;
    logic [63:0] slot_key[int unsigned];
    int unsigned stored;
    logic [31:0] n_unique, n_dup, n_discard;
    out_item_t   owed[$];
    int          errors;

    function void clear_all();
      skip1 = 8'd5; klen1 = 6'd16; skip2 = 8'd5; klen2 = 6'd16;
      position = 0; key_acc = '0; bad_seen = 0; r1_short = 0;
      slot_key.delete(); stored = 0;
      n_unique = '0; n_dup = '0; n_discard = '0;
      owed.delete(); errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CfgSkipRead1:   skip1 = val;
        CfgKeyLenRead1: klen1 = val[5:0];
        CfgSkipRead2:   skip2 = val;
        CfgKeyLenRead2: klen2 = val[5:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Linear probe from the hashed slot; free slot stores, matching slot hits.
    function logic [2:0] look_up(logic [63:0] k);
      logic [63:0] h;
      int unsigned idx;
      h = k * HashMult;
      h = h ^ (h >> 29);
      idx = 32'(h % SetCapacity);
      for (int unsigned n = 0; n < SetCapacity; n++) begin
        if (!slot_key.exists(idx)) begin
          if (stored >= SetCapacity) return VerdictFull;
          slot_key[idx] = k;
          stored++;
          return VerdictUnique;
        end
        if (slot_key[idx] == k) return VerdictDuplicate;
        idx = (idx + 1) % SetCapacity;
      end
      return VerdictFull;
    endfunction

    function void note_input(in_item_t it);
      int unsigned lo, hi;
      logic [2:0] code;
      bit short_now;
      out_item_t r;
      lo = it.second_read ? skip2 : skip1;
      hi = lo + (it.second_read ? klen2 : klen1);
      if (it.base_present) begin
        if (position >= lo && position < hi) begin
          case (it.base)
            "C", "c": code = 3'd0;
            "A", "a": code = 3'd1;
            "T", "t": code = 3'd2;
            "G", "g": code = 3'd3;
            default:  code = 3'd4;
          endcase
          if (code[2]) bad_seen = 1;
          else key_acc = {key_acc[61:0], code[1:0]};
        end
        if (position < 511) position++;
      end
      if (!it.end_of_read) return;
      short_now = position < hi;
      position = 0;
      if (!it.second_read) begin
        if (short_now) r1_short = 1;
        return;
      end
      r.pair_key = '0;
      if (r1_short || short_now) begin
        r.verdict = VerdictShort;
        if (n_discard != '1) n_discard++;
      end else if (bad_seen) begin
        r.verdict = VerdictBadBase;
        if (n_discard != '1) n_discard++;
      end else begin
        r.pair_key = key_acc;
        r.verdict = look_up(key_acc);
        if (r.verdict == VerdictUnique && n_unique != '1) n_unique++;
        if (r.verdict == VerdictDuplicate && n_dup != '1) n_dup++;
      end
      key_acc = '0; bad_seen = 0; r1_short = 0;
      r.unique_count = n_unique;
      r.duplicate_count = n_dup;
      r.discard_count = n_discard;
      owed.push_back(r);
    endfunction

    function void check(out_item_t got);
      out_item_t w;
      if (owed.size() == 0) begin
        $error("unexpected verdict transaction: verdict %0d key %h", got.verdict, got.pair_key);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (got.verdict !== w.verdict) begin
        $error("verdict: expected %0d, got %0d", w.verdict, got.verdict); errors++;
      end
      if (got.pair_key !== w.pair_key) begin
        $error("pair_key: expected %h, got %h", w.pair_key, got.pair_key); errors++;
      end
      if (got.unique_count !== w.unique_count) begin
        $error("unique_count: expected %0d, got %0d", w.unique_count, got.unique_count);
        errors++;
      end
      if (got.duplicate_count !== w.duplicate_count) begin
        $error("duplicate_count: expected %0d, got %0d", w.duplicate_count,
               got.duplicate_count);
        errors++;
      end
      if (got.discard_count !== w.discard_count) begin
        $error("discard_count: expected %0d, got %0d", w.discard_count, got.discard_count);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  verdict_board board;
  bit quiet = 0;          // no idling on either side near the end
  int hold_request = 0;   // long receiver hold-off, in cycles
  bit hold_done = 0;      // long hold-off already requested
  int item_total = 0;

  // pair buffers and a history of sent pairs for replay (duplicates)
  logic [7:0] r1buf[512], r2buf[512];
  int r1len, r2len;
  logic [7:0] h1[64][512], h2[64][512];
  int h1len[64], h2len[64];
  int hist_n = 0;

  read_pair_duplicate_filter_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Result monitor: out_stall and outputs settle before the falling edge.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) board.check(out_item);
  end

  // Receiver: random short stalls, plus a long hold-off on request.
  initial begin
    int burst, hold;
    burst = 0; hold = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Drive one transaction from a rising edge. It returns at its acceptance edge with valid
  // high, keeping the stream back to back, unless it drops valid at random and idles first.
  task automatic send_item(input in_item_t it);
    bit st;
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    board.note_input(it);
    item_total++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Idle until every owed verdict is back, then cover a trailing read-1 close.
  task automatic drain();
    go_quiet();
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_index <= 2'($urandom_range(0, 3));
    cfg_data <= 8'($urandom_range(0, 255));
  endtask

  task automatic set_cfg(input int s1, input int k1, input int s2, input int k2);
    drain();
    write_cfg(CfgSkipRead1, 8'(s1));
    write_cfg(CfgKeyLenRead1, 8'(k1));
    write_cfg(CfgSkipRead2, 8'(s2));
    write_cfg(CfgKeyLenRead2, 8'(k2));
  endtask

  function automatic logic [7:0] pick_base();
    logic [7:0] acgt[8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
    return acgt[$urandom_range(0, 7)];
  endfunction

  // Build a read into buf: good length, short, or with a bad base in the window.
  task automatic make_read(output logic [7:0] buf_o[512], output int len, input int lo,
                           input int klen, input bit too_short, input bit bad);
    int stop;
    stop = lo + klen;
    if (too_short && stop > 0) len = $urandom_range(0, stop - 1);
    else len = stop + $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      buf_o[i] = pick_base();
      // noise outside the window may be any byte
      if ((i < lo || i >= stop) && $urandom_range(0, 9) == 0)
        buf_o[i] = 8'($urandom_range(0, 255));
    end
    if (bad && klen > 0 && len > lo) begin
      buf_o[lo + $urandom_range(0, klen - 1) % (len - lo)] = 8'($urandom_range(0, 255));
    end
  endtask

  // Send one read; close on the last base or with an empty closing item.
  // flip: occasionally toggle the read flag on a base inside the read.
  task automatic send_read(input logic [7:0] b[512], input int len, input bit second,
                           input bit flip);
    in_item_t it;
    bit empty_close;
    empty_close = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      it.base = b[i];
      it.base_present = 1'b1;
      it.second_read = second ^ (flip && $urandom_range(0, 7) == 0);
      it.end_of_read = (i == len - 1) && !empty_close;
      if (it.end_of_read) it.second_read = second;
      send_item(it);
      if ($urandom_range(0, 40) == 0) begin
        // empty item that does nothing
        it.base = 8'($urandom_range(0, 255));
        it.base_present = 1'b0;
        it.end_of_read = 1'b0;
        it.second_read = 1'($urandom_range(0, 1));
        send_item(it);
      end
    end
    if (empty_close) begin
      it.base = 8'($urandom_range(0, 255));
      it.base_present = 1'b0;
      it.second_read = second;
      it.end_of_read = 1'b1;
      send_item(it);
    end
  endtask

  // One pair: mostly well formed, sometimes replayed, short, bad or broken.
  task automatic send_pair();
    int sel, slot;
    sel = $urandom_range(0, 99);
    if (sel < 30 && hist_n > 0) begin
      slot = $urandom_range(0, (hist_n < 64 ? hist_n : 64) - 1);
      send_read(h1[slot], h1len[slot], 1'b0, 1'b0);
      send_read(h2[slot], h2len[slot], 1'b1, 1'b0);
      return;
    end
    make_read(r1buf, r1len, board.skip1, board.klen1, sel >= 80 && sel < 85,
              sel >= 90 && sel < 93);
    make_read(r2buf, r2len, board.skip2, board.klen2, sel >= 85 && sel < 90,
              sel >= 93 && sel < 96);
    if (sel == 96) begin
      send_read(r2buf, r2len, 1'b1, 1'b0);          // read 1 missing
    end else if (sel == 97) begin
      send_read(r1buf, r1len, 1'b0, 1'b0);          // read 1 repeated
      send_read(r1buf, r1len, 1'b0, 1'b0);
      send_read(r2buf, r2len, 1'b1, 1'b0);
    end else begin
      send_read(r1buf, r1len, 1'b0, sel >= 98);
      send_read(r2buf, r2len, 1'b1, sel >= 98);
      if (sel < 80) begin
        slot = hist_n % 64;
        h1[slot] = r1buf; h1len[slot] = r1len;
        h2[slot] = r2buf; h2len[slot] = r2len;
        hist_n++;
      end
    end
  endtask

  task automatic send_text(input string s, input bit second);
    for (int i = 0; i < s.len(); i++) r1buf[i] = s[i];
    send_read(r1buf, s.len(), second, 1'b0);
  endtask

  initial begin
    board = new();
    board.clear_all();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tiny windows so each pair is a handful of transactions.
    set_cfg(0, 2, 0, 2);
    send_text("AC", 0); send_text("GT", 1);        // unique
    send_text("ac", 0); send_text("gt", 1);        // same key, lower case: duplicate
    send_text("AN", 0); send_text("GT", 1);        // bad base in window
    send_text("A", 0);  send_text("GT", 1);        // short read 1
    send_text("CC", 0); send_text("G", 1);         // short read 2
    send_text("TA", 1);                            // read 1 missing
    send_text("", 0);   send_text("", 1);          // empty reads
    drain();

    // Extremes of the registers, including key overflow and zero windows.
    set_cfg(0, 0, 0, 32);
    repeat (12) send_pair();
    set_cfg(0, 32, 0, 32);
    repeat (12) send_pair();
    set_cfg(255, 8, 3, 0);
    repeat (3) send_pair();
    set_cfg(5, 16, 5, 16);
    repeat (6) send_pair();

    // Main random phase on small windows so duplicates are common.
    set_cfg(2, 4, 1, 4);
    while (item_total < 500) begin
      send_pair();
      if (!hold_done && item_total > 300) begin
        hold_request = 300;
        hold_done = 1;
      end
    end
    drain();                                        // sender waits for all verdicts
    set_cfg(1, 6, 0, 10);
    quiet = 1;
    while (item_total < 700) send_pair();

    drain();
    for (int i = 0; i < 100000 && board.pending() != 0; i++) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: covers the reset clearing sweep plus the whole stream many times over.
  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/rpdf_pkg.sv
rtl/rpdf_ram.sv
rtl/rpdf_ctrl.sv
rtl/rpdf_datapath.sv
rtl/read_pair_duplicate_filter_unit.sv
test/tb_top.sv
